[rtl/core/stor_pkg.sv]
// Shared types and constants for the sample table offset resolver.
`default_nettype none
package stor_pkg;

    localparam int RunEntriesDef    = 256;
    localparam int ChunkEntriesDef  = 4096;
    localparam int SampleEntriesDef = 4096;

    localparam int IdxW    = 12;
    localparam int ChunkW  = 13;
    localparam int ValW    = 32;
    localparam int RunCntW = 9;
    localparam int CntW    = 13;
    localparam int SpanW   = 26;

    // Input operation codes
    localparam logic [1:0] OP_RUN     = 2'd0;
    localparam logic [1:0] OP_CHUNK   = 2'd1;
    localparam logic [1:0] OP_SIZE    = 2'd2;
    localparam logic [1:0] OP_RESOLVE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_RUN_COUNT    = 2'd0;
    localparam logic [1:0] CFG_CHUNK_COUNT  = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;

    typedef struct packed {
        logic [ChunkW-1:0] lead_chunk;
        logic [ChunkW-1:0] spc;
    } t_run;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_CUR,
        S_END,
        S_MUL,
        S_CMP,
        S_DIV,
        S_CHUNK,
        S_CHUNKD,
        S_SUM,
        S_LAST,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/core/sample_table_offset_resolver.sv]
// A table write is taken in the idle state; a resolve walks the run entries in the
// fetch, current, end, multiply and compare states, runs the chunk divide, reads the
// chunk offset and then the sample sizes from the chunk's first sample up to the sample.
// Throughput: one item at a time; the walk over the run memory and the data memory
// read port set how long a resolve takes. A finished result waits in the output register.
// Reset clears control state and the count registers; tables are undefined until written.
`default_nettype none
module sample_table_offset_resolver #(
    parameter int RUN_ENTRIES    = stor_pkg::RunEntriesDef,
    parameter int CHUNK_ENTRIES  = stor_pkg::ChunkEntriesDef,
    parameter int SAMPLE_ENTRIES = stor_pkg::SampleEntriesDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [stor_pkg::IdxW-1:0]   i_index,
    input  wire logic [stor_pkg::ChunkW-1:0] i_run_first_chunk,
    input  wire logic [stor_pkg::ChunkW-1:0] i_run_samples_per_chunk,
    input  wire logic [stor_pkg::ValW-1:0]   i_table_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [stor_pkg::ValW-1:0]        o_sample_offset,
    output logic [stor_pkg::ValW-1:0]        o_sample_size,
    output logic [stor_pkg::IdxW-1:0]        o_chunk_index,
    output logic [stor_pkg::IdxW-1:0]        o_chunk_first_sample,
    output logic                             o_found,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [stor_pkg::CntW-1:0]   i_cfg_data
);
    import stor_pkg::*;

    localparam int RAW = (RUN_ENTRIES > 1) ? $clog2(RUN_ENTRIES) : 1;
    localparam int DataDepth = CHUNK_ENTRIES + SAMPLE_ENTRIES;
    localparam int DAW = $clog2(DataDepth);

    t_run            run_mem [RUN_ENTRIES];
    logic [ValW-1:0] data_mem [DataDepth];

    t_state r_state, n_state;

    logic [RunCntW-1:0] r_run_cnt;
    logic [CntW-1:0]    r_chunk_cnt;
    logic [CntW-1:0]    r_sample_cnt;

    logic [IdxW-1:0]    r_sample;
    logic [RunCntW-1:0] r_i;
    logic [IdxW-1:0]    r_base;
    logic [ChunkW-1:0]  r_start;
    logic [ChunkW-1:0]  r_spc;
    logic [ChunkW-1:0]  r_n;
    logic               r_skip;
    logic [SpanW-1:0]   r_span;
    logic               r_found;
    logic [IdxW-1:0]    r_chunk0;
    logic [IdxW-1:0]    r_first;
    logic [IdxW-1:0]    r_j;
    logic               r_pend;
    logic [ValW-1:0]    r_acc;
    logic [ValW-1:0]    r_size;

    t_run            r_run_rd;
    logic [ValW-1:0] r_data_rd;

    logic               r_out_valid;
    logic [ValW-1:0]    r_out_offset;
    logic [ValW-1:0]    r_out_size;
    logic [IdxW-1:0]    r_out_chunk;
    logic [IdxW-1:0]    r_out_first;
    logic               r_out_found;

    logic               in_xfer;
    logic               run_we;
    logic               data_we;
    logic [DAW-1:0]     data_wa;
    logic [RAW-1:0]     run_ra;
    logic [DAW-1:0]     data_ra;
    logic [RunCntW-1:0] runs;
    logic [CntW-1:0]    chunks;
    logic [CntW-1:0]    samples;
    logic               has_next;
    logic [ChunkW-1:0]  end_raw;
    logic [ChunkW-1:0]  end_c;
    logic               skip;
    logic [SpanW:0]     lim;
    logic               hit;
    logic               more_runs;
    logic               resolve_ok;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [IdxW-1:0]    div_q;
    logic [ChunkW-1:0]  div_r;
    logic [ChunkW-1:0]  chunk1;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        runs    = (32'(r_run_cnt) < RUN_ENTRIES) ? r_run_cnt : RunCntW'(RUN_ENTRIES);
        chunks  = (32'(r_chunk_cnt) < CHUNK_ENTRIES) ? r_chunk_cnt : CntW'(CHUNK_ENTRIES);
        samples = (32'(r_sample_cnt) < SAMPLE_ENTRIES) ? r_sample_cnt
                                                       : CntW'(SAMPLE_ENTRIES);
        has_next  = ({1'b0, r_i} + 10'd1) < {1'b0, runs};
        more_runs = has_next;
        resolve_ok = ({1'b0, i_index} < samples) && (runs != '0);
        if (has_next) begin
            end_raw = (r_run_rd.lead_chunk != '0) ? r_run_rd.lead_chunk - 13'd1 : '0;
        end else begin
            end_raw = chunks;
        end
        end_c = (end_raw > chunks) ? chunks : end_raw;
        skip  = (end_c < r_start) || (r_spc == '0);
        lim   = (SpanW+1)'(r_base) + (SpanW+1)'(r_span);
        hit   = !r_skip && ((SpanW+1)'(r_sample) < lim);
        chunk1 = r_start + ChunkW'(div_q);
    end

    // Table writes and reads
    always_comb begin
        run_we  = in_xfer && (i_operation == OP_RUN) && (32'(i_index) < RUN_ENTRIES);
        data_we = 1'b0;
        data_wa = DAW'(32'(i_index));
        if (in_xfer && (i_operation == OP_CHUNK) && (32'(i_index) < CHUNK_ENTRIES)) begin
            data_we = 1'b1;
        end
        if (in_xfer && (i_operation == OP_SIZE) && (32'(i_index) < SAMPLE_ENTRIES)) begin
            data_we = 1'b1;
            data_wa = DAW'(32'(CHUNK_ENTRIES) + 32'(i_index));
        end
        run_ra = (r_state == S_CUR) ? RAW'(32'(r_i) + 32'd1) : RAW'(32'(r_i));
        if (r_state == S_CHUNK) begin
            data_ra = DAW'(32'(chunk1) - 32'd1);
        end else begin
            data_ra = DAW'(32'(CHUNK_ENTRIES) + 32'(r_j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_we) begin
            run_mem[RAW'(32'(i_index))] <= '{lead_chunk: i_run_first_chunk,
                                             spc: i_run_samples_per_chunk};
        end
        r_run_rd <= run_mem[run_ra];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[data_wa] <= i_table_value;
        end
        r_data_rd <= data_mem[data_ra];
    end

    stor_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_sample - r_base),
        .i_divisor   (r_spc),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_operation == OP_RESOLVE)) begin
                    n_state = resolve_ok ? S_FETCH : S_DONE;
                end
            end
            S_FETCH:  n_state = S_CUR;
            S_CUR:    n_state = S_END;
            S_END:    n_state = S_MUL;
            S_MUL:    n_state = S_CMP;
            S_CMP: begin
                if (hit) begin
                    n_state = S_DIV;
                end else if (more_runs) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV:    n_state = div_done ? S_CHUNK : S_DIV;
            S_CHUNK:  n_state = S_CHUNKD;
            S_CHUNKD: n_state = S_SUM;
            S_SUM:    n_state = (r_j == r_sample) ? S_LAST : S_SUM;
            S_LAST:   n_state = S_DONE;
            S_DONE:   n_state = out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        div_start = (r_state == S_CMP) && hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_cnt    <= '0;
            r_chunk_cnt  <= '0;
            r_sample_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RUN_COUNT:    r_run_cnt    <= RunCntW'(i_cfg_data);
                    CFG_CHUNK_COUNT:  r_chunk_cnt  <= i_cfg_data;
                    CFG_SAMPLE_COUNT: r_sample_cnt <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk and sum datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sample <= i_index;
                r_i      <= '0;
                r_base   <= '0;
                r_found  <= 1'b0;
            end
            S_CUR: begin
                r_start <= (r_run_rd.lead_chunk == '0) ? 13'd1 : r_run_rd.lead_chunk;
                r_spc   <= r_run_rd.spc;
            end
            S_END: begin
                r_skip <= skip;
                r_n    <= end_c - r_start + 13'd1;
            end
            S_MUL: begin
                r_span <= SpanW'(r_n) * SpanW'(r_spc);
            end
            S_CMP: begin
                if (hit) begin
                    r_found <= 1'b1;
                end else begin
                    // base stays at or below the sample while the walk goes on
                    if (!r_skip) begin
                        r_base <= IdxW'(lim);
                    end
                    r_i <= r_i + 9'd1;
                end
            end
            S_CHUNK: begin
                r_chunk0 <= IdxW'(chunk1 - 13'd1);
                r_first  <= r_sample - IdxW'(div_r);
                r_j      <= r_sample - IdxW'(div_r);
            end
            S_CHUNKD: begin
                r_acc  <= r_data_rd;
                r_pend <= 1'b0;
            end
            S_SUM: begin
                if (r_pend) begin
                    r_acc <= r_acc + r_data_rd;
                end
                r_pend <= 1'b1;
                if (r_j != r_sample) begin
                    r_j <= r_j + 12'd1;
                end
            end
            S_LAST: begin
                r_size <= r_data_rd;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_found  <= r_found;
            r_out_offset <= r_found ? r_acc : '0;
            r_out_size   <= r_found ? r_size : '0;
            r_out_chunk  <= r_found ? r_chunk0 : '0;
            r_out_first  <= r_found ? r_first : '0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_sample_offset      = r_out_offset;
    assign o_sample_size        = r_out_size;
    assign o_chunk_index        = r_out_chunk;
    assign o_chunk_first_sample = r_out_first;
    assign o_found              = r_out_found;

endmodule
`default_nettype wire

[rtl/core/stor_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module stor_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [stor_pkg::IdxW-1:0]   i_dividend,
    input  wire logic [stor_pkg::ChunkW-1:0] i_divisor,
    output logic                            o_done,
    output logic [stor_pkg::IdxW-1:0]        o_quotient,
    output logic [stor_pkg::ChunkW-1:0]      o_remainder
);
    import stor_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [3:0]          r_cnt;
    logic [IdxW-1:0]     r_quo;
    logic [ChunkW-1:0]   r_rem;
    logic [ChunkW-1:0]   r_dvs;
    logic [ChunkW:0]     rem_sh;
    logic                fits;

    always_comb begin
        rem_sh = {r_rem, r_quo[IdxW-1]};
        fits   = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(IdxW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[IdxW-2:0], fits};
            r_rem <= fits ? ChunkW'(rem_sh - {1'b0, r_dvs}) : ChunkW'(rem_sh);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

[rtl/core/stor_chk.sv]
// Port-level checks for the sample table offset resolver, bound to the top level.
`default_nettype none
module stor_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic [1:0]                  i_operation,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [stor_pkg::ValW-1:0]   o_sample_offset,
    input wire logic [stor_pkg::ValW-1:0]   o_sample_size,
    input wire logic [stor_pkg::IdxW-1:0]   o_chunk_index,
    input wire logic [stor_pkg::IdxW-1:0]   o_chunk_first_sample,
    input wire logic                        o_found
);
    import stor_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_sample_offset == '0 && o_sample_size == '0
            && o_chunk_index == '0 && o_chunk_first_sample == '0)
        else $error("unresolved result carries nonzero fields");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation != OP_RESOLVE) && !o_out_valid
            |=> !o_out_valid)
        else $error("table write produced a result");

endmodule

bind sample_table_offset_resolver stor_chk u_stor_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_ready           (o_in_ready),
    .i_operation          (i_operation),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_sample_offset      (o_sample_offset),
    .o_sample_size        (o_sample_size),
    .o_chunk_index        (o_chunk_index),
    .o_chunk_first_sample (o_chunk_first_sample),
    .o_found              (o_found)
);
`default_nettype wire
